>>> hw/rtl/aff2d_pkg.sv
// Shared types, constants and fixed-point helpers for the affine 2D transform unit.
package aff2d_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 3;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int RND_W     = PROD_W - FRAC_BITS;
    localparam int SUM_W     = RND_W + 2;

    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        KIND_IDENTITY  = 3'd0,
        KIND_MULTIPLY  = 3'd1,
        KIND_ROTATE    = 3'd2,
        KIND_SCALE     = 3'd3,
        KIND_SHEAR     = 3'd4,
        KIND_TRANSLATE = 3'd5,
        KIND_TRANSFORM = 3'd6
    } t_kind;

    // operands of one matrix entry lane: a0*b0 +/- a1*b1 + addend
    typedef struct packed {
        logic signed [DATA_W-1:0] a0;
        logic signed [DATA_W-1:0] b0;
        logic signed [DATA_W-1:0] a1;
        logic signed [DATA_W-1:0] b1;
        logic signed [DATA_W-1:0] addend;
        logic                     sub;
    } t_lane_op;

    // exact product, shifted right by FRAC_BITS, rounded to nearest, ties up
    function automatic logic signed [RND_W-1:0] fmul(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] q;
        p = a * b;
        q = (p + (PROD_W'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        return q[RND_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] s);
        logic signed [DATA_W-1:0] r;
        if (s[SUM_W-1] == 1'b0 && s[SUM_W-2:DATA_W-1] != '0) begin
            r = SAT_MAX;
        end else if (s[SUM_W-1] == 1'b1 && s[SUM_W-2:DATA_W-1] != '1) begin
            r = SAT_MIN;
        end else begin
            r = s[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/affine_2d_transform_unit.sv
// Top level: 2x3 affine matrix state, request decode and stream handshakes.
//
//  channel   dir  payload                                           role
//  s_axis    in   tuser: kind[2:0]; tdata: val0..val5 (32b each)    operation requests
//  m_axis    out  tdata: out_x[31:0], out_y[63:32]                  transformed points
//
// Throughput is one request per cycle while the input is not stalled; a transform result
// is offered after passing the input register, then the result register. Each lane does two
// 32x32 multiplies plus a three-term add and saturate combinationally, feeding the matrix
// register directly so the next request sees the updated matrix.
// Reset loads the identity matrix and clears both valid flags. Input stalls only while
// a transform waits in the input register on a full result register not being taken.
module affine_2d_transform_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [191:0] i_s_axis_tdata,   // val0 [31:0], val1, val2, val3, val4, val5 [191:160]
    input  logic [2:0]   i_s_axis_tuser,   // kind [2:0]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [63:0]  o_m_axis_tdata    // out_x [31:0], out_y [63:32]
);

    localparam int DW = aff2d_pkg::DATA_W;

    // input register
    logic                                r_in_vld;
    logic [aff2d_pkg::KIND_W-1:0]        r_in_kind;
    logic signed [DW-1:0]                r_in_val [6];

    // matrix state, row-major: [row][col]
    logic signed [DW-1:0]                r_mat [2][3];
    logic signed [DW-1:0]                n_mat [2][3];

    // result register
    logic                                r_out_vld;
    logic signed [DW-1:0]                r_out_x;
    logic signed [DW-1:0]                r_out_y;

    aff2d_pkg::t_lane_op                 lane_op  [2][3];
    logic signed [DW-1:0]                lane_sum [2][3];

    logic is_xform;
    logic blocked;
    logic advance;

    assign is_xform = (r_in_kind == aff2d_pkg::KIND_TRANSFORM);
    // a transform can only leave the input register if the result slot frees up
    assign blocked  = r_in_vld && is_xform && r_out_vld && !i_m_axis_tready;
    assign advance  = r_in_vld && !blocked;

    assign o_s_axis_tready = !blocked;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_y, r_out_x};

    // operand steering per lane; lane (r,j) produces entry m[r][j]
    always_comb begin
        for (int r = 0; r < 2; r++) begin
            for (int j = 0; j < 3; j++) begin
                lane_op[r][j] = '0;
                unique case (r_in_kind)
                    aff2d_pkg::KIND_MULTIPLY: begin
                        lane_op[r][j].a0 = r_mat[r][0];
                        lane_op[r][j].b0 = r_in_val[j];
                        lane_op[r][j].a1 = r_mat[r][1];
                        lane_op[r][j].b1 = r_in_val[3+j];
                        if (j == 2) begin
                            lane_op[r][j].addend = r_mat[r][2];
                        end
                    end
                    aff2d_pkg::KIND_ROTATE: begin
                        // row0 = row0*cos - row1*sin; row1 = row1*cos + row0*sin
                        lane_op[r][j].a0  = r_mat[r][j];
                        lane_op[r][j].b0  = r_in_val[0];
                        lane_op[r][j].a1  = r_mat[1-r][j];
                        lane_op[r][j].b1  = r_in_val[1];
                        lane_op[r][j].sub = (r == 0);
                    end
                    aff2d_pkg::KIND_SCALE: begin
                        lane_op[r][j].a0 = r_mat[r][j];
                        lane_op[r][j].b0 = r_in_val[r];
                    end
                    aff2d_pkg::KIND_SHEAR: begin
                        lane_op[r][j].a0     = r_in_val[r];
                        lane_op[r][j].b0     = r_mat[1-r][j];
                        lane_op[r][j].addend = r_mat[r][j];
                    end
                    aff2d_pkg::KIND_TRANSLATE: begin
                        // v * 1.0 rounds back to v exactly
                        lane_op[r][j].a0     = r_in_val[r];
                        lane_op[r][j].b0     = aff2d_pkg::ONE;
                        lane_op[r][j].addend = r_mat[r][j];
                    end
                    aff2d_pkg::KIND_TRANSFORM: begin
                        if (j == 2) begin
                            lane_op[r][j].a0     = r_mat[r][0];
                            lane_op[r][j].b0     = r_in_val[0];
                            lane_op[r][j].a1     = r_mat[r][1];
                            lane_op[r][j].b1     = r_in_val[1];
                            lane_op[r][j].addend = r_mat[r][2];
                        end
                    end
                    default: begin
                        lane_op[r][j] = '0;
                    end
                endcase
            end
        end
    end

    for (genvar gr = 0; gr < 2; gr++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            aff2d_lane u_lane (
                .i_op  (lane_op[gr][gj]),
                .o_sum (lane_sum[gr][gj])
            );
        end
    end

    // next matrix value
    always_comb begin
        for (int r = 0; r < 2; r++) begin
            for (int j = 0; j < 3; j++) begin
                n_mat[r][j] = r_mat[r][j];
                unique case (r_in_kind)
                    aff2d_pkg::KIND_IDENTITY: begin
                        n_mat[r][j] = (r == j) ? aff2d_pkg::ONE : '0;
                    end
                    aff2d_pkg::KIND_MULTIPLY,
                    aff2d_pkg::KIND_ROTATE,
                    aff2d_pkg::KIND_SCALE,
                    aff2d_pkg::KIND_SHEAR: begin
                        n_mat[r][j] = lane_sum[r][j];
                    end
                    aff2d_pkg::KIND_TRANSLATE: begin
                        if (j == 2) begin
                            n_mat[r][j] = lane_sum[r][j];
                        end
                    end
                    default: begin
                        n_mat[r][j] = r_mat[r][j];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int r = 0; r < 2; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r_mat[r][j] <= (r == j) ? aff2d_pkg::ONE : '0;
                end
            end
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end

            if (advance) begin
                r_mat <= n_mat;
            end

            if (advance && is_xform) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_kind <= i_s_axis_tuser;
            for (int k = 0; k < 6; k++) begin
                r_in_val[k] <= i_s_axis_tdata[k*DW +: DW];
            end
        end
        if (advance && is_xform) begin
            r_out_x <= lane_sum[0][2];
            r_out_y <= lane_sum[1][2];
        end
    end

`ifndef SYNTHESIS
    a_xform_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_xform) |=> r_out_vld)
        else $error("transform request did not load the result register");

    a_no_spurious_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_vld && !(advance && is_xform)) |=> !r_out_vld)
        else $error("result valid raised without a transform request");

    a_hold_matrix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance || is_xform) |=> ($stable(r_mat[0][0]) && $stable(r_mat[0][1])
            && $stable(r_mat[0][2]) && $stable(r_mat[1][0]) && $stable(r_mat[1][1])
            && $stable(r_mat[1][2])))
        else $error("matrix changed without an updating request");

    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_kind == aff2d_pkg::KIND_IDENTITY)
            |=> (r_mat[0][0] == aff2d_pkg::ONE && r_mat[1][1] == aff2d_pkg::ONE
                 && r_mat[0][2] == '0 && r_mat[1][2] == '0))
        else $error("identity request did not load the unit matrix");

    a_stall_only_xform: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_vld && is_xform && r_out_vld))
        else $error("input stalled without a pending transform");
`endif

endmodule

>>> hw/rtl/aff2d_lane.sv
// One matrix entry lane: two rounded fixed-point products, exact sum, saturation.
module aff2d_lane (
    input  aff2d_pkg::t_lane_op                   i_op,
    output logic signed [aff2d_pkg::DATA_W-1:0]   o_sum
);

    logic signed [aff2d_pkg::RND_W-1:0] p0;
    logic signed [aff2d_pkg::RND_W-1:0] p1;
    logic signed [aff2d_pkg::SUM_W-1:0] s;

    always_comb begin
        p0 = aff2d_pkg::fmul(i_op.a0, i_op.b0);
        p1 = aff2d_pkg::fmul(i_op.a1, i_op.b1);
        if (i_op.sub) begin
            s = aff2d_pkg::SUM_W'(p0) - aff2d_pkg::SUM_W'(p1)
                + aff2d_pkg::SUM_W'(i_op.addend);
        end else begin
            s = aff2d_pkg::SUM_W'(p0) + aff2d_pkg::SUM_W'(p1)
                + aff2d_pkg::SUM_W'(i_op.addend);
        end
        o_sum = aff2d_pkg::sat32(s);
    end

endmodule

>>> tb/tb_affine_2d_transform_unit.sv
// Self-checking testbench for the affine 2D transform unit: directed and random requests.
`timescale 1ns / 1ps

module tb_affine_2d_transform_unit;

    // No acceptance on either side for this many cycles ends the run.
    // The long output hold-off and random idling both stay well short of this limit.
    localparam int STALL_LIMIT = 2000;
    // Result register sits behind the input register; drain with margin.
    localparam int DRAIN_CYCLES = 10;
    // Kind code with no operation behind it.
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [191:0] i_s_axis_tdata = '0;   // val0 [31:0], val1, val2, val3, val4, val5 [191:160]
    logic [2:0]   i_s_axis_tuser = '0;   // kind [2:0]
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [63:0]  o_m_axis_tdata;        // out_x [31:0], out_y [63:32]

    affine_2d_transform_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predicted matrix, order m00 m01 m02 m10 m11 m12, and pending points {y, x}.
    logic signed [31:0] matrix [6];
    logic [63:0]        expected_points [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;    // receiver holds tready low while nonzero
    int requests_sent = 0;
    int directed_requests = 0;
    int points_checked = 0;
    int error_count = 0;
    int stall_cycles = 0;

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------

    // Exact product, shifted down by FRAC_BITS, rounded to nearest with ties up.
    function automatic longint qmul(input logic signed [31:0] a, input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return (p + (longint'(1) <<< (aff2d_pkg::FRAC_BITS - 1))) >>> aff2d_pkg::FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint s);
        if (s > longint'(aff2d_pkg::SAT_MAX)) begin
            return aff2d_pkg::SAT_MAX;
        end else if (s < longint'(aff2d_pkg::SAT_MIN)) begin
            return aff2d_pkg::SAT_MIN;
        end
        return s[31:0];
    endfunction

    function automatic void load_identity();
        matrix[0] = aff2d_pkg::ONE;
        matrix[1] = '0;
        matrix[2] = '0;
        matrix[3] = '0;
        matrix[4] = aff2d_pkg::ONE;
        matrix[5] = '0;
    endfunction

    // Applies one accepted request to the matrix copy; a transform queues its point.
    function automatic void predict_request(input logic [2:0] kind, input logic [191:0] ops);
        logic signed [31:0] v [6];
        logic signed [31:0] m00, m01, m02, m10, m11, m12;
        logic signed [31:0] px, py;
        for (int i = 0; i < 6; i++) begin
            v[i] = ops[32*i +: 32];
        end
        m00 = matrix[0]; m01 = matrix[1]; m02 = matrix[2];
        m10 = matrix[3]; m11 = matrix[4]; m12 = matrix[5];
        case (kind)
            aff2d_pkg::KIND_IDENTITY: begin
                load_identity();
            end
            aff2d_pkg::KIND_MULTIPLY: begin
                matrix[0] = clamp32(qmul(m00, v[0]) + qmul(m01, v[3]));
                matrix[1] = clamp32(qmul(m00, v[1]) + qmul(m01, v[4]));
                matrix[2] = clamp32(qmul(m00, v[2]) + qmul(m01, v[5]) + longint'(m02));
                matrix[3] = clamp32(qmul(m10, v[0]) + qmul(m11, v[3]));
                matrix[4] = clamp32(qmul(m10, v[1]) + qmul(m11, v[4]));
                matrix[5] = clamp32(qmul(m10, v[2]) + qmul(m11, v[5]) + longint'(m12));
            end
            aff2d_pkg::KIND_ROTATE: begin
                matrix[0] = clamp32(qmul(m00, v[0]) - qmul(m10, v[1]));
                matrix[1] = clamp32(qmul(m01, v[0]) - qmul(m11, v[1]));
                matrix[2] = clamp32(qmul(m02, v[0]) - qmul(m12, v[1]));
                matrix[3] = clamp32(qmul(m00, v[1]) + qmul(m10, v[0]));
                matrix[4] = clamp32(qmul(m01, v[1]) + qmul(m11, v[0]));
                matrix[5] = clamp32(qmul(m02, v[1]) + qmul(m12, v[0]));
            end
            aff2d_pkg::KIND_SCALE: begin
                matrix[0] = clamp32(qmul(m00, v[0]));
                matrix[1] = clamp32(qmul(m01, v[0]));
                matrix[2] = clamp32(qmul(m02, v[0]));
                matrix[3] = clamp32(qmul(m10, v[1]));
                matrix[4] = clamp32(qmul(m11, v[1]));
                matrix[5] = clamp32(qmul(m12, v[1]));
            end
            aff2d_pkg::KIND_SHEAR: begin
                matrix[0] = clamp32(longint'(m00) + qmul(v[0], m10));
                matrix[1] = clamp32(longint'(m01) + qmul(v[0], m11));
                matrix[2] = clamp32(longint'(m02) + qmul(v[0], m12));
                matrix[3] = clamp32(longint'(m10) + qmul(v[1], m00));
                matrix[4] = clamp32(longint'(m11) + qmul(v[1], m01));
                matrix[5] = clamp32(longint'(m12) + qmul(v[1], m02));
            end
            aff2d_pkg::KIND_TRANSLATE: begin
                matrix[2] = clamp32(longint'(m02) + longint'(v[0]));
                matrix[5] = clamp32(longint'(m12) + longint'(v[1]));
            end
            aff2d_pkg::KIND_TRANSFORM: begin
                px = clamp32(qmul(m00, v[0]) + qmul(m01, v[1]) + longint'(m02));
                py = clamp32(qmul(m10, v[0]) + qmul(m11, v[1]) + longint'(m12));
                expected_points.push_back({py, px});
            end
            default: begin
                // unused kind: no effect
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Operand generation
    // ------------------------------------------------------------------

    function automatic logic [191:0] pack6(input logic [31:0] v0, input logic [31:0] v1,
                                           input logic [31:0] v2, input logic [31:0] v3,
                                           input logic [31:0] v4, input logic [31:0] v5);
        return {v5, v4, v3, v2, v1, v0};
    endfunction

    // Uniform fixed-point value within +/- units.
    function automatic logic [31:0] rand_fixed(input int units);
        int span;
        int r;
        span = units << aff2d_pkg::FRAC_BITS;
        r = int'($urandom_range(0, 2 * span)) - span;
        return r;
    endfunction

    function automatic logic [31:0] rand_corner();
        case ($urandom_range(0, 6))
            0: return aff2d_pkg::SAT_MAX;
            1: return aff2d_pkg::SAT_MIN;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4: return 32'h1;
            5: return aff2d_pkg::ONE;
            default: return -aff2d_pkg::ONE;
        endcase
    endfunction

    // Mostly moderate values, with full-range words and corners mixed in.
    function automatic logic [31:0] rand_mixed(input int units);
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return rand_corner();
            default: return rand_fixed(units);
        endcase
    endfunction

    // Operands suited to one request kind; unused fields carry noise.
    function automatic logic [191:0] gen_ops(input logic [2:0] kind);
        logic [191:0] ops;
        int units;
        for (int i = 0; i < 6; i++) begin
            ops[32*i +: 32] = $urandom;
        end
        case (kind)
            aff2d_pkg::KIND_MULTIPLY:  units = 2;
            aff2d_pkg::KIND_ROTATE:    units = 1;
            aff2d_pkg::KIND_SCALE:     units = 4;
            aff2d_pkg::KIND_SHEAR:     units = 2;
            aff2d_pkg::KIND_TRANSLATE: units = 64;
            default:                   units = 256;
        endcase
        if (kind == aff2d_pkg::KIND_MULTIPLY) begin
            for (int i = 0; i < 6; i++) begin
                ops[32*i +: 32] = ($urandom_range(0, 7) == 0) ? rand_mixed(units)
                                                              : rand_fixed(units);
            end
        end else if (kind != aff2d_pkg::KIND_IDENTITY) begin
            for (int i = 0; i < 2; i++) begin
                ops[32*i +: 32] = (kind == aff2d_pkg::KIND_TRANSFORM
                                   || $urandom_range(0, 7) == 0)
                                  ? rand_mixed(units) : rand_fixed(units);
            end
        end
        return ops;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: one request, held until the block takes it
    // ------------------------------------------------------------------

    task automatic send_request(input logic [2:0] kind, input logic [191:0] ops);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= ops;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        predict_request(kind, ops);
        requests_sent++;
    endtask

    // ------------------------------------------------------------------
    // Receiver, result checker and watchdog
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h (point %0d)", what, got, want,
                 points_checked);
        error_count++;
    endtask

    always @(posedge i_clk) begin : point_checker
        logic [63:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("point with none pending, x", o_m_axis_tdata[31:0], '0);
            end else begin
                want = expected_points.pop_front();
                if (o_m_axis_tdata[31:0] !== want[31:0]) begin
                    report_mismatch("out_x", o_m_axis_tdata[31:0], want[31:0]);
                end
                if (o_m_axis_tdata[63:32] !== want[63:32]) begin
                    report_mismatch("out_y", o_m_axis_tdata[63:32], want[63:32]);
                end
            end
            points_checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Identity after reset passes points through; the unused kind is a no-op.
    task automatic test_reset_state();
        send_request(aff2d_pkg::KIND_TRANSFORM,
                     pack6(aff2d_pkg::SAT_MAX, aff2d_pkg::SAT_MIN, 0, 0, 0, 0));
        send_request(KIND_UNUSED, '1);
        send_request(aff2d_pkg::KIND_TRANSFORM,
                     pack6(32'h0001_8000, 32'hFFFD_C000, '1, '1, '1, '1));
    endtask

    // Each matrix update followed by a point through the new matrix.
    task automatic test_each_operation();
        send_request(aff2d_pkg::KIND_SCALE,
                     pack6(32'h0002_0000, 32'h0000_8000, '1, '1, '1, '1));
        send_request(aff2d_pkg::KIND_TRANSFORM,
                     pack6(aff2d_pkg::ONE, -aff2d_pkg::ONE, 0, 0, 0, 0));
        // quarter turn: cos 0, sin 1
        send_request(aff2d_pkg::KIND_ROTATE, pack6(32'h0, aff2d_pkg::ONE, '1, '1, '1, '1));
        send_request(aff2d_pkg::KIND_TRANSFORM,
                     pack6(32'h0003_0000, 32'h0001_4000, 0, 0, 0, 0));
        send_request(aff2d_pkg::KIND_SHEAR,
                     pack6(32'h0000_8000, 32'hFFFF_C000, '1, '1, '1, '1));
        send_request(aff2d_pkg::KIND_TRANSFORM,
                     pack6(aff2d_pkg::ONE, aff2d_pkg::ONE, 0, 0, 0, 0));
        send_request(aff2d_pkg::KIND_TRANSLATE,
                     pack6(32'h0003_0000, 32'hFFFC_0000, '1, '1, '1, '1));
        send_request(aff2d_pkg::KIND_TRANSFORM,
                     pack6(aff2d_pkg::ONE, aff2d_pkg::ONE, 0, 0, 0, 0));
        send_request(aff2d_pkg::KIND_MULTIPLY,
                     pack6(32'h0001_4000, 32'hFFFF_8000, 32'h0005_0000,
                           32'h0000_2000, 32'hFFFE_0000, 32'h0001_2345));
        send_request(aff2d_pkg::KIND_TRANSFORM,
                     pack6(32'h0002_8000, 32'hFFFF_0001, 0, 0, 0, 0));
        send_request(aff2d_pkg::KIND_IDENTITY, '1);
        send_request(aff2d_pkg::KIND_TRANSFORM,
                     pack6(32'h0000_0003, 32'h0000_0005, '1, '1, '1, '1));
    endtask

    // Rounding ties in both signs, then saturation at both ends of the range.
    task automatic test_rounding_and_saturation();
        send_request(aff2d_pkg::KIND_SCALE, pack6(32'h0000_8000, 32'h0000_8000, 0, 0, 0, 0));
        send_request(aff2d_pkg::KIND_TRANSFORM, pack6(32'h1, 32'hFFFF_FFFF, 0, 0, 0, 0));
        send_request(aff2d_pkg::KIND_TRANSLATE,
                     pack6(aff2d_pkg::SAT_MAX, aff2d_pkg::SAT_MIN, 0, 0, 0, 0));
        send_request(aff2d_pkg::KIND_TRANSLATE,
                     pack6(aff2d_pkg::SAT_MAX, aff2d_pkg::SAT_MIN, 0, 0, 0, 0));
        send_request(aff2d_pkg::KIND_TRANSFORM, pack6(0, 0, 0, 0, 0, 0));
        send_request(aff2d_pkg::KIND_SCALE,
                     pack6(aff2d_pkg::SAT_MAX, aff2d_pkg::SAT_MIN, 0, 0, 0, 0));
        send_request(aff2d_pkg::KIND_TRANSFORM,
                     pack6(aff2d_pkg::SAT_MAX, aff2d_pkg::SAT_MIN, 0, 0, 0, 0));
        send_request(aff2d_pkg::KIND_MULTIPLY,
                     pack6(aff2d_pkg::SAT_MIN, aff2d_pkg::SAT_MIN, aff2d_pkg::SAT_MIN,
                           aff2d_pkg::SAT_MIN, aff2d_pkg::SAT_MIN, aff2d_pkg::SAT_MIN));
        send_request(aff2d_pkg::KIND_TRANSFORM, pack6(32'hFFFF_FFFF, 32'h1, 0, 0, 0, 0));
    endtask

    // Receiver holds off while points keep coming, so the result register
    // fills and the block stalls its input; updates mixed in must not cause a stall themselves.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_request(aff2d_pkg::KIND_IDENTITY, '0);
        hold_off_cycles = 200;
        repeat (10) begin
            send_request(aff2d_pkg::KIND_TRANSFORM, gen_ops(aff2d_pkg::KIND_TRANSFORM));
            send_request(aff2d_pkg::KIND_TRANSLATE, gen_ops(aff2d_pkg::KIND_TRANSLATE));
        end
        repeat (8) begin
            send_request(aff2d_pkg::KIND_TRANSFORM, gen_ops(aff2d_pkg::KIND_TRANSFORM));
        end
    endtask

    // Mostly well-formed chains (usually an identity, a few updates, some points),
    // with bursts of fully random requests of any kind in between.
    task automatic test_random_sequences(input int n_requests, input int send_pct,
                                         input int recv_pct);
        int stop_at;
        logic [2:0] kind;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = requests_sent + n_requests;
        while (requests_sent < stop_at) begin
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 3) != 0) begin
                    send_request(aff2d_pkg::KIND_IDENTITY, gen_ops(aff2d_pkg::KIND_IDENTITY));
                end
                repeat ($urandom_range(1, 4)) begin
                    kind = 3'($urandom_range(aff2d_pkg::KIND_MULTIPLY,
                                             aff2d_pkg::KIND_TRANSLATE));
                    send_request(kind, gen_ops(kind));
                end
                repeat ($urandom_range(1, 4)) begin
                    send_request(aff2d_pkg::KIND_TRANSFORM,
                                 gen_ops(aff2d_pkg::KIND_TRANSFORM));
                end
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    send_request(3'($urandom_range(0, 7)),
                                 pack6($urandom, $urandom, $urandom, $urandom, $urandom,
                                       $urandom));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------

    initial begin
        load_identity();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 35;
        recv_idle_pct = 61;
        test_reset_state();
        test_each_operation();
        test_rounding_and_saturation();
        directed_requests = requests_sent;

        test_random_sequences(200, 35, 61);
        test_random_sequences(200, 61, 35);
        test_random_sequences(200, 0, 0);
        test_output_backpressure();

        i_s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d directed) and %0d points, incl. all kinds,",
                 requests_sent, directed_requests, points_checked);
        $display("rounding ties, saturation, idling on both sides and a long output stall.");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/aff2d_pkg.sv
hw/rtl/aff2d_lane.sv
hw/rtl/affine_2d_transform_unit.sv
tb/tb_affine_2d_transform_unit.sv
